@@ hw/rtl/lsms_pkg.sv @@
`default_nettype none

package lsms_pkg;

    localparam int DIST_W = 14;
    localparam int SECTOR_COUNT = 12;
    localparam int SECTOR_W = 4;
    localparam int DEFAULT_SECTOR_WIDTH = 30;
    localparam int CFG_INDEX_W = 2;
    localparam int SPEED_W = 13;
    localparam int STEER_W = 11;
    localparam int ANGLE_W = 5;
    localparam int MODE_W = 2;

    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [SECTOR_W-1:0] sector_t;
    typedef dist_t [SECTOR_COUNT-1:0] minima_t;
    typedef logic [SPEED_W-1:0] speed_t;
    typedef logic [STEER_W-1:0] steer_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_NEAR  = 2'd1,
        MODE_CLOSE = 2'd2
    } mode_t;

    localparam cfg_index_t CFG_NEAR_THRESHOLD  = 2'd0;
    localparam cfg_index_t CFG_CLOSE_THRESHOLD = 2'd1;

    localparam dist_t EMPTY_MIN = 14'd9999;
    localparam dist_t NEAR_THRESHOLD_RESET = 14'd600;
    localparam dist_t CLOSE_THRESHOLD_RESET = 14'd400;

    localparam speed_t SPEED_CLEAR = 13'd5000;
    localparam speed_t SPEED_NEAR  = 13'd3750;
    localparam speed_t SPEED_CLOSE = 13'd3125;

    localparam steer_t STEER_CENTER     = 11'd1430;
    localparam steer_t STEER_NEAR_LEFT  = 11'd1263;
    localparam steer_t STEER_NEAR_RIGHT = 11'd1596;
    localparam steer_t STEER_HARD_LEFT  = 11'd1230;
    localparam steer_t STEER_HARD_RIGHT = 11'd1630;

    localparam angle_t ANGLE_ZERO       = 5'sd0;
    localparam angle_t ANGLE_NEAR_LEFT  = 5'sd10;
    localparam angle_t ANGLE_NEAR_RIGHT = -5'sd10;
    localparam angle_t ANGLE_HARD_LEFT  = 5'sd12;
    localparam angle_t ANGLE_HARD_RIGHT = -5'sd12;

    localparam int FRONT_LEFT  = 5;
    localparam int FRONT_RIGHT = 6;
    localparam int NEAR_SIDE_L = 4;
    localparam int NEAR_SIDE_R = 7;
    localparam int WIDE_SIDE_L = 3;
    localparam int WIDE_SIDE_R = 8;

    typedef struct packed {
        logic    valid;
        dist_t   distance;
        sector_t sector;
        logic    last;
    } item_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsms_front.sv @@
`default_nettype none

module lsms_front #(
    parameter int SECTOR_WIDTH = lsms_pkg::DEFAULT_SECTOR_WIDTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_stall,
    input  wire lsms_pkg::dist_t distance,
    input  wire logic            advance,
    output lsms_pkg::item_t      item
);

    localparam int POS_W = (SECTOR_WIDTH > 1) ? $clog2(SECTOR_WIDTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_WIDTH - 1);
    localparam lsms_pkg::sector_t SECTOR_LAST = lsms_pkg::sector_t'(lsms_pkg::SECTOR_COUNT - 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    lsms_pkg::sector_t sector_reg, sector_next;
    lsms_pkg::item_t   item_reg, item_next;
    logic              accept;
    logic              pos_wrap;
    logic              scan_end;

    assign sample_stall = item_reg.valid && !advance;
    assign accept = sample_valid && !sample_stall;
    assign pos_wrap = (pos_reg == POS_LAST);
    assign scan_end = pos_wrap && (sector_reg == SECTOR_LAST);

    always_comb
    begin
        pos_next = pos_reg;
        sector_next = sector_reg;
        item_next = item_reg;
        if (advance)
        begin
            item_next.valid = 1'b0;
        end
        if (accept)
        begin
            item_next.valid = 1'b1;
            item_next.distance = distance;
            item_next.sector = sector_reg;
            item_next.last = scan_end;
            if (pos_wrap)
            begin
                pos_next = '0;
                sector_next = scan_end ? '0 : sector_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sector_reg <= '0;
            item_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sector_reg <= sector_next;
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lsms_minima.sv @@
`default_nettype none

module lsms_minima (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire lsms_pkg::item_t item,
    output lsms_pkg::minima_t    minima
);

    lsms_pkg::minima_t minima_reg, minima_next;

    always_comb
    begin
        minima_next = minima_reg;
        if (advance)
        begin
            for (int k = 0; k < lsms_pkg::SECTOR_COUNT; k++)
            begin
                if (item.last)
                begin
                    minima_next[k] = lsms_pkg::EMPTY_MIN;
                end
                else if (item.sector == lsms_pkg::sector_t'(k) && item.distance != '0
                         && item.distance < minima_reg[k])
                begin
                    minima_next[k] = item.distance;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minima_reg <= {lsms_pkg::SECTOR_COUNT{lsms_pkg::EMPTY_MIN}};
        end
        else
        begin
            minima_reg <= minima_next;
        end
    end

    assign minima = minima_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lsms_steer.sv @@
`default_nettype none

module lsms_steer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              decide,
    input  wire lsms_pkg::minima_t minima,
    input  wire lsms_pkg::dist_t   near_threshold,
    input  wire lsms_pkg::dist_t   close_threshold,
    output logic                   slot_free,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output lsms_pkg::speed_t       speed_compare,
    output lsms_pkg::steer_t       steer_compare,
    output lsms_pkg::angle_t       steer_angle,
    output lsms_pkg::mode_t        mode
);

    lsms_pkg::dist_t  m_fl, m_fr, m_nl, m_nr, m_wl, m_wr;
    logic             near_band;
    logic             close_hit;
    lsms_pkg::speed_t speed_d;
    lsms_pkg::steer_t steer_d;
    lsms_pkg::angle_t angle_d;
    lsms_pkg::mode_t  mode_d;

    logic             valid_reg, valid_next;
    lsms_pkg::speed_t speed_reg;
    lsms_pkg::steer_t steer_reg;
    lsms_pkg::angle_t angle_reg;
    lsms_pkg::mode_t  mode_reg;

    assign m_fl = minima[lsms_pkg::FRONT_LEFT];
    assign m_fr = minima[lsms_pkg::FRONT_RIGHT];
    assign m_nl = minima[lsms_pkg::NEAR_SIDE_L];
    assign m_nr = minima[lsms_pkg::NEAR_SIDE_R];
    assign m_wl = minima[lsms_pkg::WIDE_SIDE_L];
    assign m_wr = minima[lsms_pkg::WIDE_SIDE_R];

    assign near_band = (m_fl < near_threshold && m_fl > close_threshold)
                    || (m_fr < near_threshold && m_fr > close_threshold);
    assign close_hit = (m_fl <= close_threshold) || (m_fr <= close_threshold);

    always_comb
    begin
        mode_d = lsms_pkg::MODE_CLEAR;
        speed_d = lsms_pkg::SPEED_CLEAR;
        steer_d = lsms_pkg::STEER_CENTER;
        angle_d = lsms_pkg::ANGLE_ZERO;
        if (near_band)
        begin
            mode_d = lsms_pkg::MODE_NEAR;
            speed_d = lsms_pkg::SPEED_NEAR;
            if (m_nl > m_nr)
            begin
                angle_d = lsms_pkg::ANGLE_NEAR_LEFT;
                steer_d = lsms_pkg::STEER_NEAR_LEFT;
            end
            else if (m_nl < m_nr)
            begin
                angle_d = lsms_pkg::ANGLE_NEAR_RIGHT;
                steer_d = lsms_pkg::STEER_NEAR_RIGHT;
            end
        end
        else if (close_hit)
        begin
            mode_d = lsms_pkg::MODE_CLOSE;
            speed_d = lsms_pkg::SPEED_CLOSE;
            if (m_wl < m_wr)
            begin
                angle_d = lsms_pkg::ANGLE_HARD_LEFT;
                steer_d = lsms_pkg::STEER_HARD_LEFT;
            end
            else if (m_wl > m_wr)
            begin
                angle_d = lsms_pkg::ANGLE_HARD_RIGHT;
                steer_d = lsms_pkg::STEER_HARD_RIGHT;
            end
        end
    end

    assign slot_free = !valid_reg || !result_stall;
    assign valid_next = decide || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            speed_reg <= speed_d;
            steer_reg <= steer_d;
            angle_reg <= angle_d;
            mode_reg <= mode_d;
        end
    end

    assign result_valid = valid_reg;
    assign speed_compare = speed_reg;
    assign steer_compare = steer_reg;
    assign steer_angle = angle_reg;
    assign mode = mode_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lidar_sector_min_steer.sv @@
`default_nettype none

// Takes one range sample per cycle while sample_stall is low, 12 * SECTOR_WIDTH
// samples per scan, and keeps the minimum nonzero distance of each of the 12
// sectors. One item is taken every such cycle; each sample but the last of a
// scan passes the input register and updates its sector minimum in the next
// cycle. The last sample of a scan is not folded into a minimum; at the edge
// where it leaves the input register, a steering result is loaded into the
// result register and the minima reload to 9999. sample_stall rises only while
// the last sample of a scan waits for a result that has not been taken yet.
// Threshold writes are accepted in every cycle and should be done between scans.
module lidar_sector_min_steer #(
    parameter int SECTOR_WIDTH = lsms_pkg::DEFAULT_SECTOR_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire lsms_pkg::cfg_index_t cfg_index,
    input  wire lsms_pkg::dist_t      cfg_data,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire lsms_pkg::dist_t      distance,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output lsms_pkg::speed_t          speed_compare,
    output lsms_pkg::steer_t          steer_compare,
    output lsms_pkg::angle_t          steer_angle,
    output logic [lsms_pkg::MODE_W-1:0] mode
);

    lsms_pkg::dist_t   near_threshold_reg, near_threshold_next;
    lsms_pkg::dist_t   close_threshold_reg, close_threshold_next;
    lsms_pkg::item_t   item;
    lsms_pkg::minima_t minima;
    lsms_pkg::mode_t   mode_code;
    logic              slot_free;
    logic              advance;
    logic              decide;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        near_threshold_next = near_threshold_reg;
        close_threshold_next = close_threshold_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lsms_pkg::CFG_NEAR_THRESHOLD:  near_threshold_next = cfg_data;
                lsms_pkg::CFG_CLOSE_THRESHOLD: close_threshold_next = cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_threshold_reg <= lsms_pkg::NEAR_THRESHOLD_RESET;
            close_threshold_reg <= lsms_pkg::CLOSE_THRESHOLD_RESET;
        end
        else
        begin
            near_threshold_reg <= near_threshold_next;
            close_threshold_reg <= close_threshold_next;
        end
    end

    assign advance = item.valid && (!item.last || slot_free);
    assign decide = advance && item.last;

    lsms_front #(
        .SECTOR_WIDTH(SECTOR_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .distance    (distance),
        .advance     (advance),
        .item        (item)
    );

    lsms_minima u_minima (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (item),
        .minima (minima)
    );

    lsms_steer u_steer (
        .clk            (clk),
        .rst_n          (rst_n),
        .decide         (decide),
        .minima         (minima),
        .near_threshold (near_threshold_reg),
        .close_threshold(close_threshold_reg),
        .slot_free      (slot_free),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .speed_compare  (speed_compare),
        .steer_compare  (steer_compare),
        .steer_angle    (steer_angle),
        .mode           (mode_code)
    );

    assign mode = lsms_pkg::MODE_W'(mode_code);

    assert property (@(posedge clk) disable iff (!rst_n)
        decide |=> result_valid)
        else $error("scan end did not produce a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        decide |=> (minima[lsms_pkg::FRONT_LEFT] == lsms_pkg::EMPTY_MIN
                    && minima[lsms_pkg::FRONT_RIGHT] == lsms_pkg::EMPTY_MIN))
        else $error("minima not reloaded after scan end");

    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid |-> (item.sector < lsms_pkg::sector_t'(lsms_pkg::SECTOR_COUNT)))
        else $error("sector index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (item.valid && item.last && result_valid && result_stall))
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import lsms_pkg::*;

    localparam int SECTOR_WIDTH = DEFAULT_SECTOR_WIDTH;
    localparam int SCAN_LEN = SECTOR_COUNT * SECTOR_WIDTH;
    localparam int HOLD_CYCLES = 900;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int SCANS_PER_PHASE = 5;
    localparam int MAX_REPORTS = 10;

    localparam cfg_index_t CFG_SPARE_A = 2'd2;
    localparam cfg_index_t CFG_SPARE_B = 2'd3;

    typedef struct packed {
        speed_t speed;
        steer_t steer;
        angle_t angle;
        mode_t  mode;
    } steer_result_t;

    typedef struct packed {
        dist_t         row_near;
        dist_t         row_close;
        dist_t         s3;
        dist_t         s4;
        dist_t         s5;
        dist_t         s6;
        dist_t         s7;
        dist_t         s8;
        logic          typed;
        steer_result_t want;
    } scan_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = '0;
    dist_t      cfg_data = '0;
    logic       sample_valid = 1'b0;
    logic       sample_stall;
    dist_t      distance = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    speed_t     speed_compare;
    steer_t     steer_compare;
    angle_t     steer_angle;
    logic [MODE_W-1:0] mode;

    // predictor state
    minima_t     minima;
    int unsigned scan_pos;
    dist_t       near_thr;
    dist_t       close_thr;

    steer_result_t pending_steer[$];
    steer_result_t predicted;
    steer_result_t oldest;
    steer_result_t override_res;
    logic          override_on = 1'b0;
    int            fail_count = 0;

    int send_idle = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    scan_row_t scan_rows[$];

    lidar_sector_min_steer #(
        .SECTOR_WIDTH(SECTOR_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .distance(distance),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .speed_compare(speed_compare),
        .steer_compare(steer_compare),
        .steer_angle(steer_angle),
        .mode(mode)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic in_band(input dist_t m);
        return m < near_thr && m > close_thr;
    endfunction

    function automatic logic scan_step(input dist_t d, output steer_result_t r);
        int unsigned sec;
        logic near_hit;
        logic close_hit;
        sec = scan_pos / SECTOR_WIDTH;
        r = '0;
        if (d != '0 && d < minima[sec])
            minima[sec] = d;
        if (scan_pos + 1 < SCAN_LEN)
        begin
            scan_pos = scan_pos + 1;
            return 1'b0;
        end
        scan_pos = 0;
        near_hit = in_band(minima[FRONT_LEFT]) || in_band(minima[FRONT_RIGHT]);
        close_hit = minima[FRONT_LEFT] <= close_thr || minima[FRONT_RIGHT] <= close_thr;
        r.angle = ANGLE_ZERO;
        r.steer = STEER_CENTER;
        if (near_hit)
        begin
            r.mode = MODE_NEAR;
            r.speed = SPEED_NEAR;
            if (minima[NEAR_SIDE_L] > minima[NEAR_SIDE_R])
            begin
                r.angle = ANGLE_NEAR_LEFT;
                r.steer = STEER_NEAR_LEFT;
            end
            else if (minima[NEAR_SIDE_L] < minima[NEAR_SIDE_R])
            begin
                r.angle = ANGLE_NEAR_RIGHT;
                r.steer = STEER_NEAR_RIGHT;
            end
        end
        else if (close_hit)
        begin
            r.mode = MODE_CLOSE;
            r.speed = SPEED_CLOSE;
            if (minima[WIDE_SIDE_L] < minima[WIDE_SIDE_R])
            begin
                r.angle = ANGLE_HARD_LEFT;
                r.steer = STEER_HARD_LEFT;
            end
            else if (minima[WIDE_SIDE_L] > minima[WIDE_SIDE_R])
            begin
                r.angle = ANGLE_HARD_RIGHT;
                r.steer = STEER_HARD_RIGHT;
            end
        end
        else
        begin
            r.mode = MODE_CLEAR;
            r.speed = SPEED_CLEAR;
        end
        for (int k = 0; k < SECTOR_COUNT; k++)
            minima[k] = EMPTY_MIN;
        return 1'b1;
    endfunction

    // prediction on accepted items, checking of accepted results
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            near_thr = NEAR_THRESHOLD_RESET;
            close_thr = CLOSE_THRESHOLD_RESET;
            scan_pos = 0;
            for (int k = 0; k < SECTOR_COUNT; k++)
                minima[k] = EMPTY_MIN;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NEAR_THRESHOLD)
                    near_thr = cfg_data;
                else if (cfg_index == CFG_CLOSE_THRESHOLD)
                    close_thr = cfg_data;
            end
            if (result_valid && !result_stall)
            begin
                if (pending_steer.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: speed %0d steer %0d angle %0d mode %0d",
                                 speed_compare, steer_compare, steer_angle, mode);
                end
                else
                begin
                    oldest = pending_steer.pop_front();
                    if (speed_compare !== oldest.speed || steer_compare !== oldest.steer
                        || steer_angle !== oldest.angle || mode !== oldest.mode)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result mismatch: speed %0d exp %0d, steer %0d exp %0d,",
                                      " angle %0d exp %0d, mode %0d exp %0d"},
                                     speed_compare, oldest.speed, steer_compare, oldest.steer,
                                     steer_angle, oldest.angle, mode, oldest.mode);
                    end
                end
            end
            if (sample_valid && !sample_stall)
            begin
                if (scan_step(distance, predicted))
                    pending_steer.push_back(override_on ? override_res : predicted);
            end
        end
    end

    // result side: random stalls plus a single long hold-off in the first random phase
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic push_sample(input dist_t d);
        while ($urandom_range(99) < send_idle)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        distance <= d;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input dist_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input dist_t nt, input dist_t ct);
        if (nt != near_thr)
            write_reg(CFG_NEAR_THRESHOLD, nt);
        if (ct != close_thr)
            write_reg(CFG_CLOSE_THRESHOLD, ct);
    endtask

    // without noise, a target of zero means a sector with no return at all
    task automatic send_scan(input minima_t targets, input logic noise);
        int pick;
        dist_t d;
        for (int s = 0; s < SECTOR_COUNT; s++)
        begin
            pick = $urandom_range(SECTOR_WIDTH - 1);
            for (int k = 0; k < SECTOR_WIDTH; k++)
            begin
                if (noise)
                    d = ($urandom_range(7) == 0) ? dist_t'(0) : dist_t'($urandom_range(16383));
                else if (targets[s] == '0)
                    d = '0;
                else if (k == pick)
                    d = targets[s];
                else if ($urandom_range(3) == 0)
                    d = '0;
                else
                    d = dist_t'($urandom_range(16383, targets[s]));
                push_sample(d);
            end
        end
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic dist_t pick_target();
        int v;
        int lo;
        int hi;
        lo = (close_thr < near_thr) ? int'(close_thr) : int'(near_thr);
        hi = (close_thr < near_thr) ? int'(near_thr) : int'(close_thr);
        case ($urandom_range(7))
            0: v = 0;
            1: v = int'(near_thr) + int'($urandom_range(2)) - 1;
            2: v = int'(close_thr) + int'($urandom_range(2)) - 1;
            3: v = $urandom_range(16383, 1);
            4: v = $urandom_range(16383, 9999);
            5: v = $urandom_range(1000, 1);
            default: v = $urandom_range(hi, lo);
        endcase
        if (v < 0)
            v = 0;
        if (v > 16383)
            v = 16383;
        return dist_t'(v);
    endfunction

    initial
    begin
        minima_t targets;
        dist_t nt;
        dist_t ct;
        scan_row_t row;

        scan_rows.push_back('{14'd600, 14'd400, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
            1'b1, '{SPEED_CLEAR, STEER_CENTER, ANGLE_ZERO, MODE_CLEAR}});
        scan_rows.push_back('{14'd600, 14'd400, 14'd50, 14'd800, 14'd500, 14'd9999, 14'd700,
            14'd60, 1'b1, '{SPEED_NEAR, STEER_NEAR_LEFT, ANGLE_NEAR_LEFT, MODE_NEAR}});
        scan_rows.push_back('{14'd600, 14'd400, 14'd50, 14'd700, 14'd500, 14'd9999, 14'd800,
            14'd60, 1'b0, '0});
        scan_rows.push_back('{14'd600, 14'd400, 14'd50, 14'd700, 14'd16383, 14'd599, 14'd700,
            14'd60, 1'b0, '0});
        scan_rows.push_back('{14'd600, 14'd400, 14'd100, 14'd900, 14'd9999, 14'd400, 14'd900,
            14'd200, 1'b0, '0});
        scan_rows.push_back('{14'd600, 14'd400, 14'd300, 14'd900, 14'd1, 14'd0, 14'd900,
            14'd200, 1'b0, '0});
        scan_rows.push_back('{14'd600, 14'd400, 14'd0, 14'd900, 14'd300, 14'd0, 14'd900,
            14'd16383, 1'b0, '0});
        scan_rows.push_back('{14'd600, 14'd400, 14'd1, 14'd2, 14'd600, 14'd16383, 14'd3,
            14'd4, 1'b0, '0});
        scan_rows.push_back('{14'd600, 14'd400, 14'd1, 14'd0, 14'd401, 14'd2000, 14'd16383,
            14'd4, 1'b0, '0});
        scan_rows.push_back('{14'd16383, 14'd9999, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
            1'b1, '{SPEED_CLOSE, STEER_CENTER, ANGLE_ZERO, MODE_CLOSE}});
        scan_rows.push_back('{14'd16383, 14'd9998, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
            1'b1, '{SPEED_NEAR, STEER_CENTER, ANGLE_ZERO, MODE_NEAR}});
        scan_rows.push_back('{14'd0, 14'd0, 14'd9, 14'd9, 14'd1, 14'd1, 14'd9, 14'd9,
            1'b1, '{SPEED_CLEAR, STEER_CENTER, ANGLE_ZERO, MODE_CLEAR}});
        scan_rows.push_back('{14'd400, 14'd600, 14'd10, 14'd700, 14'd500, 14'd9999, 14'd800,
            14'd20, 1'b0, '0});
        scan_rows.push_back('{14'd16383, 14'd0, 14'd7, 14'd5, 14'd16383, 14'd16383, 14'd3,
            14'd7, 1'b1, '{SPEED_NEAR, STEER_NEAR_LEFT, ANGLE_NEAR_LEFT, MODE_NEAR}});
        scan_rows.push_back('{14'd16383, 14'd16383, 14'd500, 14'd9, 14'd9, 14'd9, 14'd9,
            14'd100, 1'b1, '{SPEED_CLOSE, STEER_HARD_RIGHT, ANGLE_HARD_RIGHT, MODE_CLOSE}});
        scan_rows.push_back('{14'd600, 14'd400, 14'd100, 14'd50, 14'd400, 14'd9999, 14'd60,
            14'd200, 1'b0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // writes to unused indexes must leave the thresholds alone
        write_reg(CFG_SPARE_A, dist_t'($urandom));
        write_reg(CFG_SPARE_B, dist_t'($urandom));

        foreach (scan_rows[i])
        begin
            row = scan_rows[i];
            set_thresholds(row.row_near, row.row_close);
            for (int k = 0; k < SECTOR_COUNT; k++)
                targets[k] = dist_t'($urandom_range(16383));
            targets[3] = row.s3;
            targets[4] = row.s4;
            targets[5] = row.s5;
            targets[6] = row.s6;
            targets[7] = row.s7;
            targets[8] = row.s8;
            override_res = row.want;
            override_on = row.typed;
            send_scan(targets, 1'b0);
            settle();
            override_on = 1'b0;
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: begin nt = NEAR_THRESHOLD_RESET; ct = CLOSE_THRESHOLD_RESET; end
                1: begin nt = '0; ct = '0; end
                2: begin nt = 14'd16383; ct = 14'd16383; end
                3: begin nt = 14'd16383; ct = '0; end
                4:
                begin
                    nt = dist_t'($urandom_range(3000, 2));
                    ct = dist_t'($urandom_range(nt - 1, 0));
                end
                5:
                begin
                    nt = dist_t'($urandom_range(3000, 0));
                    ct = dist_t'($urandom_range(6000, nt));
                end
                6: begin nt = 14'd16383; ct = 14'd9999; end
                default:
                begin
                    nt = dist_t'($urandom_range(16383));
                    ct = dist_t'($urandom_range(16383));
                end
            endcase
            case (p % 4)
                0: begin send_idle = 0; stall_pct = 0; end
                1: begin send_idle = 79; stall_pct = 0; end
                2: begin send_idle = 0; stall_pct = 79; end
                default: begin send_idle = 7; stall_pct = 7; end
            endcase
            set_thresholds(nt, ct);
            if (p == 0)
                hold_seq++;
            repeat (SCANS_PER_PHASE)
            begin
                for (int k = 0; k < SECTOR_COUNT; k++)
                    targets[k] = pick_target();
                if ($urandom_range(2) == 0)
                    targets[NEAR_SIDE_R] = targets[NEAR_SIDE_L];
                if ($urandom_range(2) == 0)
                    targets[WIDE_SIDE_R] = targets[WIDE_SIDE_L];
                send_scan(targets, $urandom_range(5) == 0);
            end
            settle();
        end

        sample_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_steer.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_steer.size() != 0)
            $display("%0d expected results never arrived", pending_steer.size());
        if (fail_count == 0 && pending_steer.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
